FILE: src/jkv_pkg.sv
// shared types, character codes and helpers of the json key/value tokenizer
package jkv_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    M_KEYWAIT = 4'd0,
    M_KEY     = 4'd1,
    M_COLON   = 4'd2,
    M_VALUE   = 4'd3,
    M_NUM     = 4'd4,
    M_FRAC    = 4'd5,
    M_NUMTAIL = 4'd6,
    M_ARRAY   = 4'd7,
    M_ARREND  = 4'd8,
    M_STR     = 4'd9,
    M_STREND  = 4'd10,
    M_ERROR   = 4'd11
  } mode_e;

  typedef enum logic [2:0] {
    EV_KEY    = 3'd0,
    EV_INT    = 3'd1,
    EV_STRING = 3'd2,
    EV_ARRAY  = 3'd3,
    EV_OBJECT = 3'd4,
    EV_CLOSE  = 3'd5,
    EV_ERROR  = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    ERR_QUOTE   = 3'd0,
    ERR_KEY     = 3'd1,
    ERR_COLON   = 3'd2,
    ERR_BRACKET = 3'd3,
    ERR_STRING  = 3'd4,
    ERR_COMMA   = 3'd5
  } err_e;

  typedef struct packed {
    mode_e       mode;
    logic        neg;
    logic [63:0] acc;
  } state_t;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  key;
    logic [63:0] value;
    err_e        err;
    logic        last;
  } result_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic result_t mk_result(event_e kind, logic [7:0] key,
                                        logic [63:0] value, err_e err);
    result_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

FILE: src/jkv_step.sv
// next parse state and the results caused by one character
module jkv_step
  import jkv_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  state_t     state_i,
  output state_t     state_o,
  output logic [1:0] count_o,
  output result_t    res0_o,
  output result_t    res1_o
);

  logic        term;
  logic [63:0] digit;
  logic [63:0] acc_x10;
  logic [63:0] signed_val;
  result_t     r_close;
  result_t     r_int;
  result_t     r0;
  result_t     r1;
  logic [1:0]  n;
  state_t      s;

  assign term       = (data_byte_i == CH_NUL);
  assign digit      = {56'd0, data_byte_i - CH_ZERO};
  assign acc_x10    = {state_i.acc[60:0], 3'b000} + {state_i.acc[62:0], 1'b0} + digit;
  assign signed_val = state_i.neg ? (64'd0 - state_i.acc) : state_i.acc;
  assign r_close    = mk_result(EV_CLOSE, 8'd0, 64'd0, ERR_QUOTE);
  assign r_int      = mk_result(EV_INT, 8'd0, signed_val, ERR_QUOTE);

  always_comb begin
    s  = state_i;
    n  = 2'd0;
    r0 = r_close;
    r1 = r_close;
    unique case (state_i.mode)
      M_KEYWAIT, M_ARREND, M_STREND: begin
        // after a string or array an optional comma is consumed first
        if (term || ((state_i.mode == M_ARREND) && is_ws(data_byte_i))) begin
          s.mode = state_i.mode;
        end else if ((state_i.mode != M_KEYWAIT) && (data_byte_i == CH_COMMA)) begin
          s.mode = M_KEYWAIT;
        end else begin
          s.mode = M_KEYWAIT;
          if (is_ws(data_byte_i)) begin
            n = 2'd0;
          end else if (data_byte_i == CH_RBRACE) begin
            n = 2'd1;
          end else if (data_byte_i == CH_QUOTE) begin
            s.mode = M_KEY;
          end else begin
            s.mode = M_ERROR;
            n      = 2'd1;
            r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_QUOTE);
          end
        end
      end
      M_KEY: begin
        if (term) begin
          s.mode = M_ERROR;
          n      = 2'd1;
          r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_KEY);
        end else if (data_byte_i == CH_QUOTE) begin
          s.mode = M_COLON;
        end else begin
          n  = 2'd1;
          r0 = mk_result(EV_KEY, data_byte_i, 64'd0, ERR_QUOTE);
        end
      end
      M_COLON: begin
        if (data_byte_i == CH_COLON) begin
          s.mode = M_VALUE;
        end else if (!is_ws(data_byte_i)) begin
          s.mode = M_ERROR;
          n      = 2'd1;
          r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_COLON);
        end
      end
      M_VALUE: begin
        if (!is_ws(data_byte_i)) begin
          s.neg = 1'b0;
          s.acc = 64'd0;
          priority if (data_byte_i == CH_LBRACE) begin
            s.mode = M_KEYWAIT;
            n      = 2'd1;
            r0     = mk_result(EV_OBJECT, 8'd0, 64'd0, ERR_QUOTE);
          end else if (data_byte_i == CH_LBRACK) begin
            s.mode = M_ARRAY;
          end else if (data_byte_i == CH_QUOTE) begin
            s.mode = M_STR;
          end else if (data_byte_i == CH_MINUS) begin
            s.neg  = 1'b1;
            s.mode = M_NUM;
          end else if (data_byte_i == CH_PLUS) begin
            s.mode = M_NUM;
          end else if (is_digit(data_byte_i)) begin
            s.acc  = digit;
            s.mode = M_NUM;
          end else if (data_byte_i == CH_DOT) begin
            s.mode = M_FRAC;
          end else if ((data_byte_i == CH_COMMA) || (data_byte_i == CH_RBRACE)) begin
            // empty value reads as zero
            s.mode = M_KEYWAIT;
            r0     = mk_result(EV_INT, 8'd0, 64'd0, ERR_QUOTE);
            n      = (data_byte_i == CH_RBRACE) ? 2'd2 : 2'd1;
          end else begin
            s.mode = M_ERROR;
            n      = 2'd1;
            r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_COMMA);
          end
        end
      end
      M_NUM, M_FRAC, M_NUMTAIL: begin
        priority if (is_digit(data_byte_i) && (state_i.mode != M_NUMTAIL)) begin
          if (state_i.mode == M_NUM) begin
            s.acc = acc_x10;
          end
        end else if ((data_byte_i == CH_DOT) && (state_i.mode == M_NUM)) begin
          s.mode = M_FRAC;
        end else if (is_ws(data_byte_i)) begin
          s.mode = M_NUMTAIL;
        end else if ((data_byte_i == CH_COMMA) || (data_byte_i == CH_RBRACE)) begin
          s.mode = M_KEYWAIT;
          r0     = r_int;
          n      = (data_byte_i == CH_RBRACE) ? 2'd2 : 2'd1;
        end else begin
          s.mode = M_ERROR;
          n      = 2'd1;
          r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_COMMA);
        end
      end
      M_ARRAY: begin
        if (term) begin
          s.mode = M_ERROR;
          n      = 2'd1;
          r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_BRACKET);
        end else if (data_byte_i == CH_RBRACK) begin
          s.mode = M_ARREND;
          n      = 2'd1;
          r0     = mk_result(EV_ARRAY, 8'd0, 64'd0, ERR_QUOTE);
        end
      end
      M_STR: begin
        if (term) begin
          s.mode = M_ERROR;
          n      = 2'd1;
          r0     = mk_result(EV_ERROR, 8'd0, 64'd0, ERR_STRING);
        end else if (data_byte_i == CH_QUOTE) begin
          s.mode = M_STREND;
          n      = 2'd1;
          r0     = mk_result(EV_STRING, 8'd0, 64'd0, ERR_QUOTE);
        end
      end
      M_ERROR: begin
        s.mode = M_ERROR;
      end
      default: begin
        s.mode = M_ERROR;
      end
    endcase

    // terminator always returns to the key wait with a clean number
    if (term) begin
      s.mode = M_KEYWAIT;
      s.neg  = 1'b0;
      s.acc  = 64'd0;
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign state_o = s;
  assign count_o = n;
  assign res0_o  = r0;
  assign res1_o  = r1;

endmodule

FILE: src/jkv_outq.sv
// result queue taking up to two items per cycle and giving one per cycle while out_ready_i is high
module jkv_outq
  import jkv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QPtrW-1:0] wr_next;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  // two free entries are needed for a closing brace that ends a value
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));
  assign out_o       = mem_q[rd_q];
  assign wr_next     = wr_q + QPtrW'(1);

  assign wr_d  = wr_q + QPtrW'(push_cnt_i);
  assign rd_d  = rd_q + QPtrW'(pop);
  assign cnt_d = cnt_q + QCntW'(push_cnt_i) - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

endmodule

FILE: src/json_key_value_tokenizer.sv
// top level of the json key/value tokenizer
// Takes one character of a simplified JSON object body per item and gives key
// bytes, value events, closes and syntax errors as result items. A character
// is taken in every cycle while the four-entry result queue holds at most two
// items; its results are written into the queue when it is accepted and leave
// one per cycle while out_ready_i is high, so a number ended by a closing brace
// gives two items, an integer and a close. The parse state, sign and 64-bit
// accumulator update at accept, with the multiply by ten as combinational adds.
module json_key_value_tokenizer
  import jkv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_kind_o,
  output logic [7:0]         key_byte_o,
  output logic signed [63:0] int_value_o,
  output logic [2:0]         error_code_o,
  output logic               run_last_o
);

  state_t     state_q, state_d;
  state_t     step_state;
  logic [1:0] step_cnt;
  logic [1:0] push_cnt;
  result_t    res0;
  result_t    res1;
  result_t    head;
  logic       accept;

  assign accept   = in_valid_i && in_ready_o;
  assign state_d  = accept ? step_state : state_q;
  assign push_cnt = accept ? step_cnt : 2'd0;

  jkv_step u_step (
    .data_byte_i (data_byte_i),
    .state_i     (state_q),
    .state_o     (step_state),
    .count_o     (step_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  jkv_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: M_KEYWAIT, neg: 1'b0, acc: 64'd0};
    end else begin
      state_q <= state_d;
    end
  end

  assign event_kind_o = head.kind;
  assign key_byte_o   = head.key;
  assign int_value_o  = $signed(head.value);
  assign error_code_o = head.err;
  assign run_last_o   = head.last;

endmodule
